@@ sv/npair_pkg.sv @@
// Package for the MIDI track note pairer: phase codes, status codes,
// shared structs and fixed widths. No dependencies.
package npair_pkg;

  localparam int PITCH_KEYS_DEF      = 256;
  localparam int NOTES_PER_PITCH_DEF = 4;
  localparam int VARLEN_MAX_BYTES    = 4;
  localparam int OUTQ_DEPTH          = 4;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_ESCAPE    = 8'hF7;
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  typedef enum logic [2:0] {
    PH_DELTA, PH_EVENT, PH_META_TYPE, PH_LENGTH, PH_SKIP, PH_DATA1, PH_DATA2
  } phase_t;

  // One accepted byte as seen by the note queue
  typedef struct packed {
    logic        pf_en;     // prefetch pitch entry
    logic [7:0]  pf_pitch;
    logic        fin_en;    // two-data-byte event completes
    logic [7:0]  pitch;
    logic [3:0]  status_hi;
    logic [7:0]  d2;
    logic [31:0] tick;
    logic        last;      // final byte of the track
    logic [31:0] peak;
    logic        stopped;
  } event_t;

  // Work handed from the queue to the output queue, registered in the cycle after the byte
  typedef struct packed {
    logic        note_v;
    logic        sum_v;
    logic [7:0]  pitch;
    logic [31:0] off_tick;
    logic [10:0] open_count;
    logic [31:0] max_tick;
    logic [15:0] dropped;
    logic        stopped;
  } job_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  pitch;
    logic [7:0]  velocity;
    logic [31:0] on_tick;
    logic [31:0] off_tick;
    logic [10:0] open_count;
    logic [31:0] max_tick;
    logic [15:0] dropped;
    logic        stopped;
    logic        last;
  } result_t;

endpackage

@@ sv/npair_parser.sv @@
// Byte parser: delta times, running status, skipped bodies, event framing.
// Depends on npair_pkg.
module npair_parser
  import npair_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output event_t     ev
);

  phase_t      phase, phase_next;
  logic [31:0] tick_now, tick_now_next;
  logic [31:0] tick_peak, tick_peak_next;
  logic [7:0]  status_held, status_held_next;
  logic [31:0] varlen_value, varlen_value_next;
  logic [2:0]  varlen_bytes, varlen_bytes_next;
  logic [31:0] skip_left, skip_left_next;
  logic [7:0]  first_data, first_data_next;
  logic        halted, halted_next;

  logic [31:0] vl_val;
  logic [2:0]  vl_cnt;
  logic        vl_done, vl_long;
  logic [3:0]  held_hi, byte_hi;
  logic [31:0] skip_dec;

  always_comb begin
    vl_val   = {varlen_value[24:0], data_byte[6:0]};
    vl_cnt   = varlen_bytes + 3'd1;
    vl_done  = !data_byte[7];
    vl_long  = data_byte[7] && (vl_cnt >= 3'(VARLEN_MAX_BYTES));
    held_hi  = status_held[7:4];
    byte_hi  = data_byte[7:4];
    skip_dec = (skip_left != 32'd0) ? skip_left - 32'd1 : skip_left;

    phase_next        = phase;
    tick_now_next     = tick_now;
    tick_peak_next    = tick_peak;
    status_held_next  = status_held;
    varlen_value_next = varlen_value;
    varlen_bytes_next = varlen_bytes;
    skip_left_next    = skip_left;
    first_data_next   = first_data;
    halted_next       = halted;

    ev           = '0;
    ev.pitch     = first_data;
    ev.status_hi = held_hi;
    ev.d2        = data_byte;
    ev.tick      = tick_now;
    ev.pf_pitch  = data_byte;

    if (fire && !halted) begin
      unique case (phase)
        PH_DELTA, PH_LENGTH: begin
          varlen_value_next = vl_val;
          if (vl_done) begin
            varlen_bytes_next = 3'd0;
            varlen_value_next = 32'd0;
            if (phase == PH_DELTA) begin
              tick_now_next = tick_now + vl_val;
              phase_next    = PH_EVENT;
            end else begin
              skip_left_next = vl_val;
              phase_next     = (vl_val == 32'd0) ? PH_DELTA : PH_SKIP;
            end
          end else begin
            varlen_bytes_next = vl_cnt;
            if (vl_long) halted_next = 1'b1;
          end
        end
        PH_EVENT: begin
          if (tick_now > tick_peak) tick_peak_next = tick_now;
          if (data_byte == ST_META) begin
            phase_next = PH_META_TYPE;
          end else if (data_byte == ST_SYSEX || data_byte == ST_ESCAPE) begin
            phase_next = PH_LENGTH;
          end else if (data_byte[7]) begin
            status_held_next = data_byte;
            if (byte_hi == HI_PROGRAM || byte_hi == HI_PRESSURE) begin
              skip_left_next = 32'd1;
              phase_next     = PH_SKIP;
            end else begin
              phase_next = PH_DATA1;
            end
          end else if (held_hi == HI_PROGRAM || held_hi == HI_PRESSURE) begin
            phase_next = PH_DELTA;
          end else begin
            first_data_next = data_byte;
            phase_next      = PH_DATA2;
            ev.pf_en        = 1'b1;
          end
        end
        PH_META_TYPE: phase_next = PH_LENGTH;
        PH_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == 32'd0) phase_next = PH_DELTA;
        end
        PH_DATA1: begin
          first_data_next = data_byte;
          phase_next      = PH_DATA2;
          ev.pf_en        = 1'b1;
        end
        PH_DATA2: begin
          phase_next = PH_DELTA;
          ev.fin_en  = 1'b1;
        end
        default: phase_next = PH_DELTA;
      endcase
    end

    ev.last    = fire && last_byte;
    ev.peak    = tick_peak_next;
    ev.stopped = halted_next || (phase_next != PH_DELTA) || (varlen_bytes_next != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      phase        <= PH_DELTA;
      tick_now     <= '0;
      tick_peak    <= '0;
      status_held  <= '0;
      varlen_value <= '0;
      varlen_bytes <= '0;
      skip_left    <= '0;
      first_data   <= '0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      tick_now     <= tick_now_next;
      tick_peak    <= tick_peak_next;
      status_held  <= status_held_next;
      varlen_value <= varlen_value_next;
      varlen_bytes <= varlen_bytes_next;
      skip_left    <= skip_left_next;
      first_data   <= first_data_next;
      halted       <= halted_next;
    end
  end

endmodule

@@ sv/npair_queue.sv @@
// Per-pitch note FIFOs held in two synchronous memories: pitch head/fill
// and the note slots. Depends on npair_pkg.
module npair_queue
  import npair_pkg::*;
#(
  parameter int PITCH_KEYS      = PITCH_KEYS_DEF,
  parameter int NOTES_PER_PITCH = NOTES_PER_PITCH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  event_t      ev,
  output job_t        job,
  output logic [39:0] note_rdata
);

  localparam int PW    = $clog2(PITCH_KEYS);
  localparam int FW    = $clog2(NOTES_PER_PITCH + 1);
  localparam int HW    = (NOTES_PER_PITCH > 1) ? $clog2(NOTES_PER_PITCH) : 1;
  localparam int DEPTH = PITCH_KEYS * NOTES_PER_PITCH;
  localparam int AW    = $clog2(DEPTH);

  logic [FW+HW-1:0] pmeta [PITCH_KEYS];
  logic [39:0]      notes [DEPTH];
  logic [PITCH_KEYS-1:0] pvalid;

  logic [FW+HW-1:0] meta_q;
  logic             meta_v;

  logic [FW-1:0] fill, fill_next;
  logic [HW-1:0] head, head_next;
  logic [FW:0]   slot_sum;
  logic [HW-1:0] slot;
  logic          in_range, is_push, is_pop, do_push, do_pop, meta_we;
  logic [AW-1:0] note_addr;
  logic [10:0]   open_total, open_total_next;
  logic [15:0]   drop_total, drop_total_next;
  job_t          job_next;

  always_comb begin
    fill      = meta_v ? meta_q[FW-1:0] : '0;
    head      = meta_v ? meta_q[FW+HW-1:FW] : '0;
    in_range  = {1'b0, ev.pitch} < 9'(PITCH_KEYS);
    is_push   = ev.status_hi == HI_NOTE_ON && ev.d2 != 8'd0;
    is_pop    = ev.status_hi == HI_NOTE_OFF || (ev.status_hi == HI_NOTE_ON && ev.d2 == 8'd0);
    do_push   = ev.fin_en && in_range && is_push && (fill < FW'(NOTES_PER_PITCH));
    do_pop    = ev.fin_en && in_range && is_pop && (fill != '0);
    slot_sum  = (FW+1)'(head) + (FW+1)'(fill);
    slot      = (slot_sum >= (FW+1)'(NOTES_PER_PITCH))
                ? HW'(slot_sum - (FW+1)'(NOTES_PER_PITCH)) : HW'(slot_sum);
    note_addr = AW'(ev.pitch[PW-1:0]) * AW'(NOTES_PER_PITCH)
              + AW'(do_push ? slot : head);

    fill_next       = fill;
    head_next       = head;
    open_total_next = open_total;
    drop_total_next = drop_total;
    if (ev.fin_en && in_range && is_push && !do_push && drop_total != 16'hFFFF)
      drop_total_next = drop_total + 16'd1;
    if (do_push) begin
      fill_next       = fill + FW'(1);
      open_total_next = open_total + 11'd1;
    end
    if (do_pop) begin
      fill_next       = fill - FW'(1);
      head_next       = (head == HW'(NOTES_PER_PITCH - 1)) ? '0 : head + HW'(1);
      open_total_next = open_total - 11'd1;
    end
    meta_we = do_push || do_pop;

    job_next            = '0;
    job_next.note_v     = do_pop;
    job_next.sum_v      = ev.last;
    job_next.pitch      = ev.pitch;
    job_next.off_tick   = ev.tick;
    job_next.open_count = open_total_next;
    job_next.max_tick   = ev.peak;
    job_next.dropped    = drop_total_next;
    job_next.stopped    = ev.stopped;
  end

  // Pitch entry is fetched on the first data byte and used on the second;
  // its only writer is the second data byte, at least two bytes before the
  // next fetch, so reads and writes of one entry never overlap.
  always_ff @(posedge clk) begin
    if (meta_we) pmeta[ev.pitch[PW-1:0]] <= {head_next, fill_next};
    if (ev.pf_en) meta_q <= pmeta[ev.pf_pitch[PW-1:0]];
    if (do_push) notes[note_addr] <= {ev.d2, ev.tick};
    if (do_pop) note_rdata <= notes[note_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || ev.last) begin
      pvalid     <= '0;
      open_total <= '0;
      drop_total <= '0;
    end else begin
      if (meta_we) pvalid[ev.pitch[PW-1:0]] <= 1'b1;
      open_total <= open_total_next;
      drop_total <= drop_total_next;
    end
    if (rst) begin
      meta_v <= 1'b0;
    end else if (ev.pf_en) begin
      meta_v <= pvalid[ev.pf_pitch[PW-1:0]] && !ev.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job.note_v <= 1'b0;
      job.sum_v  <= 1'b0;
    end else begin
      job.note_v <= job_next.note_v;
      job.sum_v  <= job_next.sum_v;
    end
    job.pitch      <= job_next.pitch;
    job.off_tick   <= job_next.off_tick;
    job.open_count <= job_next.open_count;
    job.max_tick   <= job_next.max_tick;
    job.dropped    <= job_next.dropped;
    job.stopped    <= job_next.stopped;
  end

endmodule

@@ sv/npair_outq.sv @@
// Result queue: forms paired-note and summary results and buffers them
// toward the output stream. Depends on npair_pkg.
module npair_outq
  import npair_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  job_t        job,
  input  logic [39:0] note_rdata,
  input  logic        pop,
  output result_t     head_res,
  output logic        not_empty,
  output logic [2:0]  count
);

  result_t   buf_q [OUTQ_DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  result_t   note_res, sum_res;
  logic [1:0] n_push;

  always_comb begin
    note_res          = '0;
    note_res.pitch    = job.pitch;
    note_res.velocity = note_rdata[39:32];
    note_res.on_tick  = note_rdata[31:0];
    note_res.off_tick = job.off_tick;
    note_res.last     = !job.sum_v;

    sum_res            = '0;
    sum_res.is_summary = 1'b1;
    sum_res.open_count = job.open_count;
    sum_res.max_tick   = job.max_tick;
    sum_res.dropped    = job.dropped;
    sum_res.stopped    = job.stopped;
    sum_res.last       = 1'b1;

    n_push    = 2'(job.note_v) + 2'(job.sum_v);
    not_empty = count != 3'd0;
    head_res  = buf_q[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (job.note_v) buf_q[wr_ptr] <= note_res;
    if (job.sum_v) buf_q[wr_ptr + 2'(job.note_v)] <= sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(n_push) - 3'(pop);
    end
  end

endmodule

@@ sv/midi_track_note_pairer_core.sv @@
// Top level of the MIDI track note pairer: byte stream in, paired notes
// and track summaries out. Depends on npair_pkg and the npair_* modules.
//
// Usage:
//  - s_axis carries one track byte per request (tdata) with tlast on the
//    final byte of the track.
//  - m_axis carries results: tuser=0 a paired note, tuser=1 the track
//    summary; tlast marks the final result caused by one input byte.
//  - Throughput: one byte per cycle while s_axis_tready is high. The second
//    data byte of a note event reads its pitch entry fetched earlier by the
//    first data byte, so the pitch memory port sustains a byte every cycle.
//  - A result reaches m_axis from its accepted byte through the registered
//    memory read, then the result queue.
//  - A four-entry result queue parts the two sides; s_axis_tready drops
//    only when queued plus in-flight results leave no room for two more,
//    so a stalled receiver backs up into the input after a few results.
//  - Reset, and the last byte of each track, return all parse state, fill
//    counts and totals to zero; note slot contents are not
//    cleared (only slots inside a fill count are ever read).
module midi_track_note_pairer_core
  import npair_pkg::*;
#(
  parameter int PITCH_KEYS      = PITCH_KEYS_DEF,
  parameter int NOTES_PER_PITCH = NOTES_PER_PITCH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] pitch, [15:8] velocity, [47:16] on_tick, [79:48] off_tick,
  // [90:80] open_count, [122:91] max_tick, [138:123] dropped_count,
  // [139] stopped_early, [143:140] zero
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tuser,   // is_summary
  output logic         m_axis_tlast    // last
);

  event_t      ev;
  job_t        job;
  logic [39:0] note_rdata;
  result_t     head_res;
  logic        not_empty;
  logic [2:0]  q_count;
  logic        s_fire, m_fire;

  // Admit a byte only while two result slots remain after in-flight work
  assign s_axis_tready = (q_count + 3'(job.note_v) + 3'(job.sum_v)) <= 3'(OUTQ_DEPTH - 2);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  npair_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (s_fire),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .ev        (ev)
  );

  npair_queue #(
    .PITCH_KEYS      (PITCH_KEYS),
    .NOTES_PER_PITCH (NOTES_PER_PITCH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ev         (ev),
    .job        (job),
    .note_rdata (note_rdata)
  );

  npair_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .job        (job),
    .note_rdata (note_rdata),
    .pop        (m_fire),
    .head_res   (head_res),
    .not_empty  (not_empty),
    .count      (q_count)
  );

  assign m_axis_tvalid = not_empty;
  assign m_axis_tuser  = head_res.is_summary;
  assign m_axis_tlast  = head_res.last;
  assign m_axis_tdata  = {4'd0, head_res.stopped, head_res.dropped, head_res.max_tick,
                          head_res.open_count, head_res.off_tick, head_res.on_tick,
                          head_res.velocity, head_res.pitch};

`ifndef SYNTHESIS
  // Result queue never overruns
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    (q_count + 3'(job.note_v) + 3'(job.sum_v)) <= 3'(OUTQ_DEPTH))
    else $error("result queue overrun");

  // Final byte of a track always yields a summary next cycle
  a_sum_follows: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tlast) |=> job.sum_v)
    else $error("summary missing after last byte");

  // A summary is always the final result of its byte
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("summary without tlast");
`endif

endmodule

@@ tb/midi_track_note_pairer_core_tb.sv @@
// Testbench for midi_track_note_pairer_core: drives track bytes on s_axis and
// checks paired notes and track summaries against an in-bench note tracker.
// Depends on npair_pkg and the RTL of the core.
`timescale 1ns / 1ps

module midi_track_note_pairer_core_tb;
  import npair_pkg::*;

  localparam int KEYS  = 256;
  localparam int DEPTH = 4;
  localparam int IDLE_LIMIT = 5000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  midi_track_note_pairer_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // Tracker state for one track
  phase_t      ph;
  logic [31:0] tick_cur, tick_max, vl_acc, skip_cnt;
  logic [2:0]  vl_cnt;
  logic [7:0]  run_status, data1;
  logic        stuck;
  int          fill [KEYS];
  int          head [KEYS];
  logic [31:0] slot_tick [KEYS][DEPTH];
  logic [7:0]  slot_vel  [KEYS][DEPTH];
  int          notes_open;
  logic [15:0] drops;

  result_t     expected_results[$];
  int          mismatches;
  int          idle_cycles;
  logic        timed_out;
  logic        sender_gaps, receiver_gaps;
  logic        hold_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic is_one_data(logic [7:0] st);
    return st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE;
  endfunction

  task automatic clear_tracker();
    ph = PH_DELTA;
    tick_cur = '0; tick_max = '0; vl_acc = '0; skip_cnt = '0; vl_cnt = '0;
    run_status = '0; data1 = '0; stuck = 1'b0; notes_open = 0; drops = '0;
    for (int k = 0; k < KEYS; k++) begin
      fill[k] = 0; head[k] = 0;
    end
  endtask

  // Append one expected result at the tail
  task automatic expect_result(result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Shift one varlen byte in; 0 pending, 1 done, 2 too long
  function automatic int take_varlen(logic [7:0] c);
    vl_acc = {vl_acc[24:0], c[6:0]};
    if (!c[7]) begin
      vl_cnt = '0;
      return 1;
    end
    vl_cnt++;
    return (vl_cnt >= VARLEN_MAX_BYTES) ? 2 : 0;
  endfunction

  // Second data byte of a two-byte event: queue or pair a note
  task automatic close_event(logic [7:0] d2);
    result_t r;
    int p, h;
    p = data1;
    if (run_status[7:4] == HI_NOTE_ON && d2 != 0) begin
      if (fill[p] >= DEPTH) begin
        if (drops != 16'hFFFF) drops++;
      end else begin
        h = (head[p] + fill[p]) % DEPTH;
        slot_tick[p][h] = tick_cur;
        slot_vel[p][h]  = d2;
        fill[p]++;
        notes_open++;
      end
    end else if ((run_status[7:4] == HI_NOTE_ON || run_status[7:4] == HI_NOTE_OFF)
                 && fill[p] > 0) begin
      h = head[p];
      r = '0;
      r.pitch    = 8'(p);
      r.velocity = slot_vel[p][h];
      r.on_tick  = slot_tick[p][h];
      r.off_tick = tick_cur;
      expect_result(r);
      head[p] = (h + 1) % DEPTH;
      fill[p]--;
      notes_open--;
    end
  endtask

  task automatic predict_byte(logic [7:0] c, logic fin);
    result_t s;
    int r, n0;
    n0 = expected_results.size();
    if (!stuck) begin
      case (ph)
        PH_DELTA: begin
          r = take_varlen(c);
          if (r == 2) stuck = 1'b1;
          else if (r == 1) begin
            tick_cur += vl_acc; vl_acc = '0; ph = PH_EVENT;
          end
        end
        PH_EVENT: begin
          if (tick_cur > tick_max) tick_max = tick_cur;
          if (c == ST_META) ph = PH_META_TYPE;
          else if (c == ST_SYSEX || c == ST_ESCAPE) ph = PH_LENGTH;
          else if (c[7]) begin
            run_status = c;
            if (is_one_data(c)) begin
              skip_cnt = 1; ph = PH_SKIP;
            end else ph = PH_DATA1;
          end else if (is_one_data(run_status)) ph = PH_DELTA;
          else begin
            data1 = c; ph = PH_DATA2;
          end
        end
        PH_META_TYPE: ph = PH_LENGTH;
        PH_LENGTH: begin
          r = take_varlen(c);
          if (r == 2) stuck = 1'b1;
          else if (r == 1) begin
            skip_cnt = vl_acc; vl_acc = '0;
            ph = (skip_cnt == 0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (skip_cnt > 0) skip_cnt--;
          if (skip_cnt == 0) ph = PH_DELTA;
        end
        PH_DATA1: begin
          data1 = c; ph = PH_DATA2;
        end
        PH_DATA2: begin
          ph = PH_DELTA;
          close_event(c);
        end
        default: ph = PH_DELTA;
      endcase
    end
    if (fin) begin
      s = '0;
      s.is_summary = 1'b1;
      s.open_count = (notes_open > 2047) ? 11'd2047 : notes_open[10:0];
      s.max_tick   = tick_max;
      s.dropped    = drops;
      s.stopped    = !(!stuck && ph == PH_DELTA && vl_cnt == 0);
      expect_result(s);
      clear_tracker();
    end
    if (expected_results.size() > n0) expected_results[$].last = 1'b1;
  endtask

  // Offer one byte, hold it until accepted, then predict its results.
  // tvalid stays high on return; the next byte or an idle gap replaces it.
  task automatic send_byte(logic [7:0] c, logic fin = 1'b0);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_byte(c, fin);
    @(negedge clk);
  endtask

  task automatic send_delta(logic [31:0] d);
    int nb;
    nb = 1;
    while (nb < 4 && (d >> (7 * nb)) != 0) nb++;
    for (int i = nb - 1; i >= 0; i--) send_byte({i != 0, 7'((d >> (7 * i)) & 32'h7F)});
  endtask

  task automatic send_note(logic [7:0] st, logic [7:0] p, logic [7:0] v, logic [31:0] d = 0);
    send_delta(d);
    send_byte(st);
    send_byte(p);
    send_byte(v);
  endtask

  task automatic end_track();
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_notes_directed();
    send_note(8'h90, 8'd60, 8'd127, 32'd0);
    send_note(8'h90, 8'd60, 8'd1, 32'h0FFF_FFFF);   // four-byte delta
    send_note(8'h80, 8'd60, 8'd0, 32'd5);
    send_delta(1); send_byte(8'd60); send_byte(8'd0);   // running status
    send_note(8'h9F, 8'd255, 8'd255, 32'h80);
    send_note(8'h90, 8'd255, 8'd0);                     // note-on velocity 0 closes
    send_note(8'h80, 8'd7, 8'd9);                       // unmatched note-off
    for (int i = 0; i < 5; i++) send_note(8'h91, 8'd10, 8'(40 + i));  // fills, drops one
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_skips_directed();
    send_delta(0); send_byte(ST_META); send_byte(8'h03); send_byte(8'h02);
    send_byte(8'hAA); send_byte(8'hBB);
    send_delta(0); send_byte(ST_SYSEX); send_byte(8'h00);
    send_delta(0); send_byte(ST_ESCAPE); send_byte(8'h01); send_byte(8'hF7);
    send_delta(0); send_byte(8'hC3); send_byte(8'h05);
    send_delta(0); send_byte(8'h11);                    // running program change
    send_delta(0); send_byte(8'hF5); send_byte(8'h01); send_byte(8'h02);
    end_track();
    send_byte(8'h00); send_byte(8'h22); send_byte(8'h33, 1'b1); // no status, not a note
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); // bad delta
    send_byte(8'h90, 1'b1);
  endtask

  task automatic send_random_track(int events);
    logic [7:0] p;
    for (int e = 0; e < events; e++) begin
      p = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(60, 63));
      case ($urandom_range(0, 9))
        0: begin
          send_delta($urandom_range(0, 3)); send_byte(ST_META); send_byte(8'($urandom));
          send_byte(8'($urandom_range(0, 3)));
          for (int i = 0; i < 3; i++) if (ph == PH_SKIP) send_byte(8'($urandom));
        end
        1: send_byte(8'($urandom));                        // noise
        2: begin
          send_delta($urandom_range(0, 20)); send_byte({4'hC + 4'($urandom_range(0, 1)), 4'($urandom)});
          send_byte(8'($urandom_range(0, 127)));
        end
        3, 4: send_note({HI_NOTE_OFF, 4'($urandom)}, p, 8'($urandom), $urandom_range(0, 200));
        default: send_note({HI_NOTE_ON, 4'($urandom)}, p,
                           $urandom_range(0, 5) == 0 ? 8'd0 : 8'($urandom),
                           $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 300));
      endcase
    end
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random_tracks();
    for (int t = 0; t < 30; t++) send_random_track($urandom_range(1, 12));
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_note(8'h90, 8'd70, 8'(50 + i));
    for (int i = 0; i < 4; i++) send_note(8'h80, 8'd70, 8'd0);
    end_track();
  endtask

  task automatic test_no_idle();
    sender_gaps = 1'b0; receiver_gaps = 1'b0;
    for (int t = 0; t < 8; t++) send_random_track($urandom_range(2, 10));
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.is_summary = m_axis_tuser;
      got.pitch      = m_axis_tdata[7:0];
      got.velocity   = m_axis_tdata[15:8];
      got.on_tick    = m_axis_tdata[47:16];
      got.off_tick   = m_axis_tdata[79:48];
      got.open_count = m_axis_tdata[90:80];
      got.max_tick   = m_axis_tdata[122:91];
      got.dropped    = m_axis_tdata[138:123];
      got.stopped    = m_axis_tdata[139];
      got.last       = m_axis_tlast;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Watchdog: cycles with no request accepted on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("midi_track_note_pairer_core verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    mismatches = 0; idle_cycles = 0; timed_out = 1'b0;
    sender_gaps = 1'b1; receiver_gaps = 1'b1; hold_off = 1'b0;
    clear_tracker();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_notes_directed();
    test_skips_directed();
    test_backpressure();
    test_random_tracks();
    test_no_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("midi_track_note_pairer_core verification clean");
    else
      $display("midi_track_note_pairer_core verification failed");
    $finish;
  end

endmodule
